>>> design/siocp_pkg.sv
// shared constants, types and reset table for the super i/o config port
`default_nettype none

package siocp_pkg;

   localparam int NUM_REGS_DEF = 42;
   localparam int IDX_W        = 6;
   localparam int BYTE_W       = 8;

   localparam logic [BYTE_W-1:0] KEY_OPEN  = 8'h55;
   localparam logic [BYTE_W-1:0] KEY_CLOSE = 8'hAA;
   localparam logic [BYTE_W-1:0] READ_IDLE = 8'hFF;

   localparam logic [IDX_W-1:0] LOCK_LIMIT     = 6'h18;
   localparam logic [IDX_W-1:0] REG_FDC_CTL    = 6'h00;
   localparam logic [IDX_W-1:0] REG_LPT_CTL    = 6'h01;
   localparam logic [IDX_W-1:0] REG_UART_CTL   = 6'h02;
   localparam logic [IDX_W-1:0] REG_FDC_BASE   = 6'h20;
   localparam logic [IDX_W-1:0] REG_LPT_BASE   = 6'h23;
   localparam logic [IDX_W-1:0] REG_UART1_BASE = 6'h24;
   localparam logic [IDX_W-1:0] REG_UART2_BASE = 6'h25;
   localparam logic [IDX_W-1:0] REG_RO_A       = 6'h26;
   localparam logic [IDX_W-1:0] REG_RO_B       = 6'h27;
   localparam logic [IDX_W-1:0] REG_UART_IRQ   = 6'h28;
   localparam logic [IDX_W-1:0] REG_RO_C       = 6'h29;

   localparam logic ACT_READ   = 1'b0;
   localparam logic ACT_WRITE  = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // register file access from the top level
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [BYTE_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } siocp_rf_req_type;

   // result item, first field in the highest bits
   typedef struct packed {
      logic [2:0]        pad;
      logic [3:0]        uart2_irq;
      logic [9:0]        uart2_base;
      logic              uart2_enable;
      logic [3:0]        uart1_irq;
      logic [9:0]        uart1_base;
      logic              uart1_enable;
      logic [9:0]        lpt_base;
      logic              lpt_enable;
      logic [9:0]        fdc_base;
      logic              fdc_enable;
      logic              config_open;
      logic [BYTE_W-1:0] read_data;
   } siocp_rsp_type;

   // chip reset value of each register
   function automatic logic [BYTE_W-1:0] reg_default(input logic [IDX_W-1:0] addr);
      logic [BYTE_W-1:0] val;
      case (addr)
         6'h00:   val = 8'h28;
         6'h01:   val = 8'h9C;
         6'h02:   val = 8'h88;
         6'h03:   val = 8'h78;
         6'h06:   val = 8'hFF;
         6'h0D:   val = 8'h03;
         6'h0E:   val = 8'h02;
         6'h1E:   val = 8'h80;
         6'h20:   val = 8'hFC;
         6'h21:   val = 8'h7C;
         6'h22:   val = 8'hFD;
         6'h23:   val = 8'hDE;
         6'h24:   val = 8'hFE;
         6'h25:   val = 8'hBE;
         6'h26:   val = 8'h23;
         6'h27:   val = 8'h67;
         6'h28:   val = 8'h43;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> design/super_io_config_port.sv
// top level: super i/o index/data configuration port with decoded device outputs
// path: an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle unless the result stalls; one pass between the two registers
// the register file is a memory whose selected byte is read ahead into a register
// reset: synchronous active high; clears handshake, mode, key, lock and index, reloads decode copies
// register file entries not yet written read back their chip defaults after reset
`default_nettype none

module super_io_config_port
   import siocp_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel, one bus access per item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] write_data
   input  wire logic [1:0]  req_tuser,   // [0] action, [1] port_sel
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // [7:0] read_data, [8] config_open, [9] fdc_enable,
                                          // [19:10] fdc_base, [20] lpt_enable, [30:21] lpt_base,
                                          // [31] uart1_enable, [41:32] uart1_base,
                                          // [45:42] uart1_irq, [46] uart2_enable,
                                          // [56:47] uart2_base, [60:57] uart2_irq, [63:61] zero
);

   // input register
   logic              in_vld_ff, in_vld_in;
   logic              in_act_ff;
   logic              in_sel_ff;
   logic [BYTE_W-1:0] in_data_ff;

   // configuration state
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              open_ff, open_in;
   logic              first_ff, first_in;
   logic              lock_ff, lock_in;

   // flop copies of the registers that feed the decoders
   logic [BYTE_W-1:0] r00_ff, r00_in;
   logic [BYTE_W-1:0] r01_ff, r01_in;
   logic [BYTE_W-1:0] r02_ff, r02_in;
   logic [BYTE_W-1:0] r20_ff, r20_in;
   logic [BYTE_W-1:0] r23_ff, r23_in;
   logic [BYTE_W-1:0] r24_ff, r24_in;
   logic [BYTE_W-1:0] r25_ff, r25_in;
   logic [BYTE_W-1:0] r28_ff, r28_in;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   siocp_rsp_type     rsp_ff, rsp_in;

   logic              proc;
   logic              low_prot;
   logic              wr_blocked;
   logic              data_wr;
   logic [BYTE_W-1:0] rd_val;
   logic [BYTE_W-1:0] cur_byte;
   siocp_rf_req_type  rf_req;

   // the item in the input register moves on when the result slot is free
   assign proc       = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || proc;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !proc);
   assign rsp_vld_in = proc || (rsp_vld_ff && !rsp_tready);

   // protection of the selected register
   assign low_prot   = (idx_ff < LOCK_LIMIT) && lock_ff;
   assign wr_blocked = low_prot || (idx_ff inside {REG_RO_A, REG_RO_B, REG_RO_C});
   assign data_wr    = proc && (in_act_ff == ACT_WRITE) && (in_sel_ff == PORT_DATA)
                       && open_ff && !wr_blocked;

   // next state of the key sequence, index and lock
   always_comb begin
      idx_in   = idx_ff;
      open_in  = open_ff;
      first_in = first_ff;
      lock_in  = lock_ff;
      if (proc && (in_act_ff == ACT_WRITE)) begin
         if (in_sel_ff == PORT_INDEX) begin
            if ((in_data_ff == KEY_OPEN) && !open_ff) begin
               // second key in a row opens config mode
               open_in  = first_ff;
               first_in = !first_ff;
            end else if (open_ff) begin
               if (in_data_ff < BYTE_W'(NUM_REGS)) begin
                  idx_in = in_data_ff[IDX_W-1:0];
               end
               if (in_data_ff == KEY_CLOSE) begin
                  open_in = 1'b0;
               end
            end else begin
               first_in = 1'b0;
            end
         end else if (data_wr && (idx_ff == REG_LPT_CTL)
                      && ((in_data_ff[2:0] ^ r01_ff[2:0]) != 3'b000)) begin
            // changing the low bits of the lpt control register reloads the lock
            lock_in = !in_data_ff[3];
         end
      end
   end

   // decode copies follow data writes to their addresses
   always_comb begin
      r00_in = r00_ff;
      r01_in = r01_ff;
      r02_in = r02_ff;
      r20_in = r20_ff;
      r23_in = r23_ff;
      r24_in = r24_ff;
      r25_in = r25_ff;
      r28_in = r28_ff;
      if (data_wr) begin
         case (idx_ff)
            REG_FDC_CTL:    r00_in = in_data_ff;
            REG_LPT_CTL:    r01_in = in_data_ff;
            REG_UART_CTL:   r02_in = in_data_ff;
            REG_FDC_BASE:   r20_in = in_data_ff;
            REG_LPT_BASE:   r23_in = in_data_ff;
            REG_UART1_BASE: r24_in = in_data_ff;
            REG_UART2_BASE: r25_in = in_data_ff;
            REG_UART_IRQ:   r28_in = in_data_ff;
            default:        ;
         endcase
      end
   end

   // register file write plus read-ahead of the index after this item
   always_comb begin
      rf_req.we    = data_wr;
      rf_req.waddr = idx_ff;
      rf_req.wdata = in_data_ff;
      rf_req.raddr = idx_in;
   end

   siocp_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rf_req  (rf_req),
      .rd_byte (cur_byte)
   );

   // read value against the state before the item
   always_comb begin
      if (in_act_ff == ACT_WRITE) begin
         rd_val = '0;
      end else if (!open_ff) begin
         rd_val = READ_IDLE;
      end else if (in_sel_ff == PORT_INDEX) begin
         rd_val = {{(BYTE_W-IDX_W){1'b0}}, idx_ff};
      end else if (low_prot) begin
         rd_val = READ_IDLE;
      end else begin
         rd_val = cur_byte;
      end
   end

   // result fields, decodes taken after the access
   always_comb begin
      rsp_in = rsp_ff;
      if (proc) begin
         rsp_in.pad          = '0;
         rsp_in.read_data    = rd_val;
         rsp_in.config_open  = open_in;
         rsp_in.fdc_enable   = r00_in[3] && (r20_in[7:6] != 2'b00);
         rsp_in.fdc_base     = {r20_in[7:2], 4'b0000};
         rsp_in.lpt_enable   = r01_in[2] && (r23_in[7:6] != 2'b00);
         rsp_in.lpt_base     = {r23_in, 2'b00};
         rsp_in.uart1_enable = r02_in[3] && (r24_in[7:6] != 2'b00);
         rsp_in.uart1_base   = {r24_in[7:1], 3'b000};
         rsp_in.uart1_irq    = r28_in[7:4];
         rsp_in.uart2_enable = r02_in[7] && (r25_in[7:6] != 2'b00);
         rsp_in.uart2_base   = {r25_in[7:1], 3'b000};
         rsp_in.uart2_irq    = r28_in[3:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_act_ff  <= req_tuser[0];
         in_sel_ff  <= req_tuser[1];
         in_data_ff <= req_tdata;
      end
      rsp_ff <= rsp_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         idx_ff     <= '0;
         open_ff    <= 1'b0;
         first_ff   <= 1'b0;
         lock_ff    <= 1'b0;
         r00_ff     <= reg_default(REG_FDC_CTL);
         r01_ff     <= reg_default(REG_LPT_CTL);
         r02_ff     <= reg_default(REG_UART_CTL);
         r20_ff     <= reg_default(REG_FDC_BASE);
         r23_ff     <= reg_default(REG_LPT_BASE);
         r24_ff     <= reg_default(REG_UART1_BASE);
         r25_ff     <= reg_default(REG_UART2_BASE);
         r28_ff     <= reg_default(REG_UART_IRQ);
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         idx_ff     <= idx_in;
         open_ff    <= open_in;
         first_ff   <= first_in;
         lock_ff    <= lock_in;
         r00_ff     <= r00_in;
         r01_ff     <= r01_in;
         r02_ff     <= r02_in;
         r20_ff     <= r20_in;
         r23_ff     <= r23_in;
         r24_ff     <= r24_in;
         r25_ff     <= r25_in;
         r28_ff     <= r28_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

`default_nettype wire

>>> design/siocp_regfile.sv
// register file memory with per-entry valid bits and read-ahead of the selected entry
`default_nettype none

module siocp_regfile
   import siocp_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire siocp_rf_req_type  rf_req,
   output logic [BYTE_W-1:0]      rd_byte
);

   logic [BYTE_W-1:0] mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [BYTE_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  raddr_ff;

   always_ff @(posedge clock) begin
      if (rf_req.we) begin
         mem_ff[rf_req.waddr] <= rf_req.wdata;
      end
      // write-first on a collision so the selected byte is current
      if (rf_req.we && (rf_req.waddr == rf_req.raddr)) begin
         rdata_ff <= rf_req.wdata;
      end else begin
         rdata_ff <= mem_ff[rf_req.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         raddr_ff <= '0;
      end else begin
         if (rf_req.we) begin
            valid_ff[rf_req.waddr] <= 1'b1;
         end
         raddr_ff <= rf_req.raddr;
      end
   end

   // never-written entries read as their chip default
   assign rd_byte = valid_ff[raddr_ff] ? rdata_ff : reg_default(raddr_ff);

endmodule

`default_nettype wire

>>> design/siocp_checker.sv
// port-level checks for the super i/o config port, bound to the top level
`default_nettype none

module siocp_checker
   import siocp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   siocp_rsp_type rsp;
   assign rsp = rsp_tdata;

   // nothing comes out in the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // with config mode closed only writes (zero) or idle reads (all ones) come back
   a_closed_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.config_open) |->
         (rsp.read_data == 8'h00 || rsp.read_data == READ_IDLE))
      else $error("data returned while config mode closed");

   // a device is enabled only at a base at or above 0x100
   a_enable_base: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((!rsp.fdc_enable || rsp.fdc_base[9:8] != 2'b00) &&
          (!rsp.lpt_enable || rsp.lpt_base[9:8] != 2'b00) &&
          (!rsp.uart1_enable || rsp.uart1_base[9:8] != 2'b00) &&
          (!rsp.uart2_enable || rsp.uart2_base[9:8] != 2'b00)))
      else $error("device enabled at a low base");

   // base alignment and zero fill
   a_base_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp.fdc_base[3:0] == 4'h0 && rsp.uart1_base[2:0] == 3'h0 &&
          rsp.uart2_base[2:0] == 3'h0 && rsp.pad == 3'h0))
      else $error("misaligned base or nonzero fill");

endmodule

bind super_io_config_port siocp_checker u_siocp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> dv/sio_shadow_pkg.sv
// shadow copy of the config port state and the queue of expected responses
`timescale 1ns / 1ps

package sio_shadow_pkg;
   import siocp_pkg::*;

   class sio_port_shadow;
      logic [7:0]    regs [64];
      logic [5:0]    sel_index;
      bit            mode_open;
      bit            first_key;
      bit            low_locked;
      siocp_rsp_type expected_rsp [$];
      int unsigned   failures;

      function new();
         foreach (regs[i]) regs[i] = 8'h00;
         regs[6'h00] = 8'h28; regs[6'h01] = 8'h9C; regs[6'h02] = 8'h88;
         regs[6'h03] = 8'h78; regs[6'h06] = 8'hFF; regs[6'h0D] = 8'h03;
         regs[6'h0E] = 8'h02; regs[6'h1E] = 8'h80; regs[6'h20] = 8'hFC;
         regs[6'h21] = 8'h7C; regs[6'h22] = 8'hFD; regs[6'h23] = 8'hDE;
         regs[6'h24] = 8'hFE; regs[6'h25] = 8'hBE; regs[6'h26] = 8'h23;
         regs[6'h27] = 8'h67; regs[6'h28] = 8'h43;
         sel_index  = '0;
         mode_open  = 1'b0;
         first_key  = 1'b0;
         low_locked = 1'b0;
         failures   = 0;
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      // apply one accepted bus access and queue the response it should give
      function void note_access(logic act, logic port, logic [7:0] data);
         siocp_rsp_type want;
         logic [7:0]    old;
         want = '0;
         if (act == ACT_WRITE) begin
            if (port == PORT_INDEX) begin
               if (data == KEY_OPEN && !mode_open) begin
                  if (first_key) begin
                     mode_open = 1'b1;
                     first_key = 1'b0;
                  end else begin
                     first_key = 1'b1;
                  end
               end else if (mode_open) begin
                  if (data < NUM_REGS_DEF) sel_index = data[5:0];
                  if (data == KEY_CLOSE) mode_open = 1'b0;
               end else begin
                  first_key = 1'b0;
               end
            end else if (mode_open && !(sel_index < LOCK_LIMIT && low_locked) &&
                         !(sel_index inside {REG_RO_A, REG_RO_B, REG_RO_C})) begin
               old = regs[sel_index];
               regs[sel_index] = data;
               if (sel_index == REG_LPT_CTL && old[2:0] != data[2:0])
                  low_locked = ~data[3];
            end
         end else begin
            if (!mode_open)
               want.read_data = READ_IDLE;
            else if (port == PORT_INDEX)
               want.read_data = {2'b00, sel_index};
            else if (sel_index < LOCK_LIMIT && low_locked)
               want.read_data = READ_IDLE;
            else
               want.read_data = regs[sel_index];
         end
         want.config_open  = mode_open;
         want.fdc_enable   = regs[REG_FDC_CTL][3] & (|regs[REG_FDC_BASE][7:6]);
         want.fdc_base     = {regs[REG_FDC_BASE][7:2], 4'b0000};
         want.lpt_enable   = regs[REG_LPT_CTL][2] & (|regs[REG_LPT_BASE][7:6]);
         want.lpt_base     = {regs[REG_LPT_BASE], 2'b00};
         want.uart1_enable = regs[REG_UART_CTL][3] & (|regs[REG_UART1_BASE][7:6]);
         want.uart1_base   = {regs[REG_UART1_BASE][7:1], 3'b000};
         want.uart1_irq    = regs[REG_UART_IRQ][7:4];
         want.uart2_enable = regs[REG_UART_CTL][7] & (|regs[REG_UART2_BASE][7:6]);
         want.uart2_base   = {regs[REG_UART2_BASE][7:1], 3'b000};
         want.uart2_irq    = regs[REG_UART_IRQ][3:0];
         expected_rsp.push_back(want);
      endfunction

      function void compare_field(string name, logic [9:0] got, logic [9:0] want);
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("mismatch on %s: expected %h, got %h", name, want, got);
         end
      endfunction

      // compare one accepted response with the oldest expectation
      function void check_response(logic [63:0] raw);
         siocp_rsp_type seen;
         siocp_rsp_type want;
         seen = raw;
         if (expected_rsp.size() == 0) begin
            failures++;
            if (failures <= 10) $display("response with nothing expected: %h", raw);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("read_data",    10'(seen.read_data),    10'(want.read_data));
         compare_field("config_open",  10'(seen.config_open),  10'(want.config_open));
         compare_field("fdc_enable",   10'(seen.fdc_enable),   10'(want.fdc_enable));
         compare_field("fdc_base",     seen.fdc_base,          want.fdc_base);
         compare_field("lpt_enable",   10'(seen.lpt_enable),   10'(want.lpt_enable));
         compare_field("lpt_base",     seen.lpt_base,          want.lpt_base);
         compare_field("uart1_enable", 10'(seen.uart1_enable), 10'(want.uart1_enable));
         compare_field("uart1_base",   seen.uart1_base,        want.uart1_base);
         compare_field("uart1_irq",    10'(seen.uart1_irq),    10'(want.uart1_irq));
         compare_field("uart2_enable", 10'(seen.uart2_enable), 10'(want.uart2_enable));
         compare_field("uart2_base",   seen.uart2_base,        want.uart2_base);
         compare_field("uart2_irq",    10'(seen.uart2_irq),    10'(want.uart2_irq));
         compare_field("pad",          10'(seen.pad),          10'(want.pad));
      endfunction
   endclass

endpackage

>>> dv/testbench.sv
// top level testbench: drives bus accesses into the config port and checks every response
`timescale 1ns / 1ps

module testbench;
   import siocp_pkg::*;
   import sio_shadow_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] write_data
   logic [1:0]  req_tuser;   // [0] action, [1] port_sel
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [7:0] read_data, [8] config_open, [9] fdc_enable,
                             // [19:10] fdc_base, [20] lpt_enable, [30:21] lpt_base,
                             // [31] uart1_enable, [41:32] uart1_base, [45:42] uart1_irq,
                             // [46] uart2_enable, [56:47] uart2_base, [60:57] uart2_irq

   sio_port_shadow shadow = new();

   int unsigned items_sent   = 0;
   bit          quiet_tail   = 1'b0;  // no idling on either side near the end
   bit          lock_allowed = 1'b0;  // the lock is sticky, so it is only armed late
   bit          req_idle_on  = 1'b1;
   bit          rsp_stall_on = 1'b1;

   super_io_config_port DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("super_io_config_port regression: fail");
      $finish;
   end

   // mostly random bytes, with the decode thresholds and extremes mixed in
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners [6] = '{8'h00, 8'hFF, 8'h40, 8'h3F, 8'h80, 8'h7F};
      if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   // one bus access: optional idle burst, then hold valid until accepted
   task automatic send_access(input logic act, input logic port, input logic [7:0] data);
      int unsigned gap;
      // keep the lock flag clear during the main part: writes to the lpt control
      // register keep bit 3 set so the low registers stay reachable
      if (act == ACT_WRITE && port == PORT_DATA && !lock_allowed &&
          shadow.sel_index == REG_LPT_CTL)
         data[3] = 1'b1;
      @(negedge clock);
      if (!quiet_tail && req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= {port, act};
      do @(posedge clock); while (req_tready !== 1'b1);
      shadow.note_access(act, port, data);
      items_sent++;
   endtask

   // a well-formed config session: unlock keys, then select registers and touch them
   task automatic run_session();
      int unsigned n_regs;
      int unsigned n_ops;
      logic [7:0]  target;
      req_idle_on  = $urandom_range(0, 3) != 0;
      rsp_stall_on = $urandom_range(0, 3) != 0;
      if (!shadow.mode_open) begin
         send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
         // now and then a stray index write breaks the key pair
         if ($urandom_range(0, 7) == 0) send_access(ACT_WRITE, PORT_INDEX, pick_byte());
         send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
      end
      n_regs = $urandom_range(1, 6);
      repeat (n_regs) begin
         // mostly valid register numbers, some out-of-range index values
         if ($urandom_range(0, 7) == 0)
            target = 8'($urandom_range(NUM_REGS_DEF, 255));
         else
            target = 8'($urandom_range(0, NUM_REGS_DEF - 1));
         send_access(ACT_WRITE, PORT_INDEX, target);
         n_ops = $urandom_range(1, 4);
         repeat (n_ops) begin
            case ($urandom_range(0, 4))
               0:       send_access(ACT_READ, PORT_INDEX, pick_byte());
               1, 2:    send_access(ACT_READ, PORT_DATA, pick_byte());
               default: send_access(ACT_WRITE, PORT_DATA, pick_byte());
            endcase
         end
      end
      if ($urandom_range(0, 1) == 1) send_access(ACT_WRITE, PORT_INDEX, KEY_CLOSE);
   endtask

   // response side: random stall bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && rsp_stall_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // every accepted response is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         shadow.check_response(rsp_tdata);
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      reset      = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: closed-mode reads and writes
      send_access(ACT_READ,  PORT_INDEX, 8'h00);
      send_access(ACT_READ,  PORT_DATA,  8'hFF);
      send_access(ACT_WRITE, PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_INDEX, KEY_CLOSE);
      // broken key pair, then a good one
      send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
      send_access(ACT_WRITE, PORT_INDEX, 8'h12);
      send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
      send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
      send_access(ACT_READ,  PORT_INDEX, 8'h00);
      // read-only registers ignore writes
      send_access(ACT_WRITE, PORT_INDEX, 8'(REG_RO_A));
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);
      send_access(ACT_READ,  PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_INDEX, 8'(NUM_REGS_DEF - 1));
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);
      // index values past the file, and the open key while open, leave the index alone
      send_access(ACT_WRITE, PORT_INDEX, 8'(NUM_REGS_DEF));
      send_access(ACT_WRITE, PORT_INDEX, 8'hFF);
      send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
      send_access(ACT_READ,  PORT_INDEX, 8'hFF);
      // decode extremes
      send_access(ACT_WRITE, PORT_INDEX, 8'(REG_FDC_BASE));
      send_access(ACT_WRITE, PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);
      send_access(ACT_WRITE, PORT_INDEX, 8'(REG_UART_IRQ));
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);
      // lpt control change with bit 3 set keeps the low registers open
      send_access(ACT_WRITE, PORT_INDEX, 8'(REG_LPT_CTL));
      send_access(ACT_WRITE, PORT_DATA,  8'h9B);
      send_access(ACT_READ,  PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_INDEX, KEY_CLOSE);
      send_access(ACT_READ,  PORT_DATA,  8'h00);

      // random: mostly sessions, some raw noise accesses
      while (items_sent < 1300) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4))
               send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_byte());
         end else begin
            run_session();
         end
      end

      // last part: no idling, lock the low registers and keep hammering them
      quiet_tail   = 1'b1;
      lock_allowed = 1'b1;
      if (!shadow.mode_open) begin
         send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
         send_access(ACT_WRITE, PORT_INDEX, KEY_OPEN);
      end
      send_access(ACT_WRITE, PORT_INDEX, 8'(REG_LPT_CTL));
      send_access(ACT_WRITE, PORT_DATA, (shadow.regs[REG_LPT_CTL] ^ 8'h01) & 8'hF7);
      while (items_sent < 1450) run_session();

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then wait for any stray response
      while (shadow.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (shadow.failures == 0)
         $display("super_io_config_port regression: pass");
      else
         $display("super_io_config_port regression: fail");
      $finish;
   end

endmodule
